/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define RWE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that also holds through reset.
`define RWE_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/rwe_pkg.sv */
// Shared widths, register codes, reset values and structs.
// No dependencies.
package rwe_pkg;

    localparam int CELL_COUNT_DEF = 1024;

    localparam int CELL_W  = 10;
    localparam int DATA_W  = 32;
    localparam int S_W     = DATA_W + 1;
    localparam int W_W     = 17;
    localparam int SK_W    = 24;
    localparam int V_W     = DATA_W + 16;
    localparam int SUM_W   = 40;
    localparam int QUO_W   = 40;

    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 96;

    localparam int MUL_A_W   = 128;
    localparam int MUL_B_W   = 40;
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = MUL_B_W / MUL_DIGIT;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_ADDR_W-1:0] CFG_CMU_QUARTER       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CMU_THREE_QUARTER = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VON_KARMAN        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_YPLUS_LAMINAR     = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_RE_ENABLE     = 3'd4;

    localparam logic [DATA_W-1:0] RST_CMU_QUARTER       = 32'd35958;
    localparam logic [DATA_W-1:0] RST_CMU_THREE_QUARTER = 32'd10633;
    localparam logic [DATA_W-1:0] RST_VON_KARMAN        = 32'd26870;
    localparam logic [DATA_W-1:0] RST_YPLUS_LAMINAR     = 32'd760535;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef struct packed {
        logic [DATA_W-1:0] cq;
        logic [DATA_W-1:0] c75;
        logic [DATA_W-1:0] kappa;
        logic [DATA_W-1:0] yl;
        logic              en;
    } t_cfg;

    typedef struct packed {
        logic [CELL_W-1:0] cell_idx;
        logic [S_W-1:0]    s;
        logic [DATA_W-1:0] k;
        logic [DATA_W-1:0] nu;
        logic [DATA_W-1:0] nut;
        logic [DATA_W-1:0] grad;
        logic [W_W-1:0]    w;
        logic [SK_W-1:0]   sk;
        logic              lowre;
    } t_item;

endpackage

/* hdl/rwe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rwe_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/rwe_mul.sv */
// Shift-add multiplier, one 8-bit digit of the second operand per cycle.
// Depends on rwe_pkg.
module rwe_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rwe_pkg::MUL_A_W-1:0] i_a,
    input  logic [rwe_pkg::MUL_B_W-1:0] i_b,
    output logic                        o_done,
    output logic [rwe_pkg::MUL_A_W-1:0] o_p
);
    import rwe_pkg::*;

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic [MUL_A_W-1:0] r_a;
    logic [MUL_B_W-1:0] r_b;
    logic [MUL_A_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + r_a * MUL_A_W'(r_b[MUL_DIGIT-1:0]);
                r_a   <= r_a << MUL_DIGIT;
                r_b   <= r_b >> MUL_DIGIT;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule

/* hdl/rwe_div.sv */
// Restoring divider, one quotient bit per cycle, quotient saturated to 40 bits.
// Depends on rwe_pkg. A zero divisor gives the saturated maximum.
module rwe_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rwe_pkg::MUL_A_W-1:0] i_num,
    input  logic [rwe_pkg::MUL_A_W-1:0] i_den,
    output logic                        o_done,
    output logic [rwe_pkg::QUO_W-1:0]   o_quo
);
    import rwe_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [MUL_A_W-1:0] r_rem;
    logic [MUL_A_W-1:0] r_den;
    logic [QUO_W-1:0]   r_q;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_sat;
    logic               r_busy;
    logic               r_done;
    logic [MUL_A_W-1:0] den_half;

    assign den_half = r_den >> 1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num;
                r_den  <= i_den << QUO_W;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == '0) begin
                    // quotient of 2^40 or more, or zero divisor
                    r_sat <= (r_rem >= r_den);
                end else begin
                    r_den <= den_half;
                    if (r_rem >= den_half) begin
                        r_rem <= r_rem - den_half;
                        r_q   <= {r_q[QUO_W-2:0], 1'b1};
                    end else begin
                        r_q   <= {r_q[QUO_W-2:0], 1'b0};
                    end
                end
                if (r_cnt == CNT_W'(QUO_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_sat ? SUM_MAX : r_q;
endmodule

/* hdl/rwe_queue.sv */
// Two-entry queue of classified faces between front and back.
// Depends on rwe_pkg.
module rwe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rwe_pkg::t_item i_item,
    input  logic           i_pop,
    output rwe_pkg::t_item o_head,
    output logic           o_empty,
    output logic           o_full
);
    import rwe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_item              r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [PTR_W:0]     r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (PTR_W+1)'(QUEUE_DEPTH));
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wp] <= i_item;
                r_wp         <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

/* hdl/rwe_front.sv */
// Front part: takes a face, wraps the cell index, takes sqrt(k) and decides
// the low-Reynolds branch. Depends on rwe_pkg and rwe_mul.
module rwe_front #(
    parameter int CELL_COUNT = rwe_pkg::CELL_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rwe_pkg::t_cfg                  i_cfg,
    input  logic                           i_hold,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rwe_pkg::IN_TDATA_W-1:0] i_data,
    output logic                           o_push,
    output rwe_pkg::t_item                 o_item,
    input  logic                           i_full
);
    import rwe_pkg::*;

    typedef enum logic [2:0] {F_IDLE, F_SQRT, F_L1, F_L2, F_R, F_PUSH} t_state;

    t_state             r_state;
    logic [CELL_W-1:0]  r_cell;
    logic [DATA_W-1:0]  r_y, r_k, r_nu, r_nut, r_grad;
    logic [S_W-1:0]     r_s;
    logic [W_W-1:0]     r_w;
    logic [V_W-1:0]     r_v, r_res, r_bit;
    logic [4:0]         r_cnt;
    logic [SK_W-1:0]    r_sk;
    logic [MUL_A_W-1:0] r_t, r_left;
    logic               r_lowre;
    logic               r_wait;

    logic [V_W-1:0]     sq_sum, sq_res_nx, sq_v_nx;
    logic               sq_ge;
    logic [31:0]        mod_lim;
    logic               mod_ge;
    logic               mul_start, mul_done;
    logic [MUL_A_W-1:0] mul_a, mul_p, right;
    logic [MUL_B_W-1:0] mul_b;

    // one digit-pair of the integer square root per cycle
    always_comb begin
        sq_sum    = r_res + r_bit;
        sq_ge     = (r_v >= sq_sum);
        sq_res_nx = sq_ge ? (r_res >> 1) + r_bit : r_res >> 1;
        sq_v_nx   = sq_ge ? r_v - sq_sum : r_v;
    end

    // cell index modulo CELL_COUNT, one shifted compare-subtract per cycle
    assign mod_lim = 32'(CELL_COUNT) << r_cnt;
    assign mod_ge  = (r_cnt < 5'(CELL_W)) && (32'(r_cell) >= mod_lim);

    always_comb begin
        unique case (r_state)
            F_L1: begin
                mul_a = MUL_A_W'(i_cfg.cq);
                mul_b = MUL_B_W'(r_y);
            end
            F_L2: begin
                mul_a = r_t;
                mul_b = MUL_B_W'(r_sk);
            end
            F_R: begin
                mul_a = MUL_A_W'(i_cfg.yl);
                mul_b = MUL_B_W'(r_nu);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = (r_state == F_L1 || r_state == F_L2 || r_state == F_R) && !r_wait;
    assign right     = mul_p << 16;

    rwe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    assign o_ready = (r_state == F_IDLE) && !i_hold;
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        o_item.cell_idx = r_cell;
        o_item.s        = r_s;
        o_item.k        = r_k;
        o_item.nu       = r_nu;
        o_item.nut      = r_nut;
        o_item.grad     = r_grad;
        o_item.w        = r_w;
        o_item.sk       = r_sk;
        o_item.lowre    = r_lowre;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wait  <= 1'b0;
        end else begin
            if (mul_start) begin
                r_wait <= 1'b1;
            end
            unique case (r_state)
                F_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_cell  <= i_data[9:0];
                        r_y     <= i_data[41:10];
                        r_k     <= i_data[73:42];
                        r_nu    <= i_data[105:74];
                        r_nut   <= i_data[137:106];
                        r_grad  <= i_data[169:138];
                        r_s     <= S_W'(i_data[41:10]) + S_W'(i_data[201:170]);
                        r_w     <= i_data[218:202];
                        r_v     <= {i_data[73:42], 16'd0};
                        r_res   <= '0;
                        r_bit   <= V_W'(1) << (V_W - 2);
                        r_cnt   <= 5'(SK_W - 1);
                        r_state <= F_SQRT;
                    end
                end
                F_SQRT: begin
                    r_v   <= sq_v_nx;
                    r_res <= sq_res_nx;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt - 1'b1;
                    if (mod_ge) begin
                        r_cell <= r_cell - CELL_W'(mod_lim);
                    end
                    if (r_cnt == '0) begin
                        r_sk    <= sq_res_nx[SK_W-1:0];
                        r_state <= F_L1;
                    end
                end
                F_L1: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= mul_p;
                        r_state <= F_L2;
                    end
                end
                F_L2: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_left  <= mul_p;
                        r_state <= F_R;
                    end
                end
                F_R: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_lowre <= i_cfg.en && (r_left < right);
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

/* hdl/rwe_back.sv */
// Back part: rough-wall products and quotients, then the saturating
// read-modify-write of the cell sums. Depends on rwe_pkg, rwe_mul, rwe_div, rwe_ram.
module rwe_back #(
    parameter int CELL_COUNT = rwe_pkg::CELL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  rwe_pkg::t_cfg                   i_cfg,
    output logic                            o_clearing,
    input  rwe_pkg::t_item                  i_head,
    input  logic                            i_empty,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rwe_pkg::OUT_TDATA_W-1:0] o_data,
    output logic                            o_user
);
    import rwe_pkg::*;

    localparam int IDX_W = $clog2(CELL_COUNT);
    localparam int RAM_W = 2 * SUM_W;
    localparam int PAD_W = OUT_TDATA_W - CELL_W - 2 * SUM_W;

    typedef enum logic [3:0] {
        B_CLEAR, B_IDLE, B_D, B_N1, B_N2, B_N3, B_Q1, B_Q2,
        B_G1, B_G2, B_DIV1, B_DIV2, B_RD, B_ACC
    } t_state;

    t_state                 r_state;
    t_item                  r_item;
    logic [IDX_W-1:0]       r_clr;
    logic                   r_wait;
    logic [MUL_A_W-1:0]     r_d, r_n, r_n2, r_t;
    logic [SUM_W-1:0]       r_eps, r_gen;
    logic                   r_ovalid;
    logic [OUT_TDATA_W-1:0] r_odata;
    logic                   r_ouser;

    logic                   mul_start, mul_done, div_start, div_done;
    logic [MUL_A_W-1:0]     mul_a, mul_p, div_num;
    logic [MUL_B_W-1:0]     mul_b;
    logic [QUO_W-1:0]       div_quo;
    logic                   out_free;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr, idx;
    logic [RAM_W-1:0]       ram_wdata, ram_rdata;
    logic [SUM_W:0]         dis_sum, prod_sum;
    logic [SUM_W-1:0]       n_dis, n_prod;

    always_comb begin
        unique case (r_state)
            B_D: begin
                mul_a = r_item.lowre ? MUL_A_W'(r_item.s) : MUL_A_W'(i_cfg.kappa);
                mul_b = MUL_B_W'(r_item.s);
            end
            B_N1: begin
                mul_a = r_item.lowre ? MUL_A_W'(r_item.k) : MUL_A_W'(i_cfg.c75);
                mul_b = MUL_B_W'(r_item.w);
            end
            B_N2: begin
                mul_a = r_t;
                mul_b = r_item.lowre ? MUL_B_W'(r_item.nu) : MUL_B_W'(r_item.k);
            end
            B_N3: begin
                mul_a = r_t;
                mul_b = MUL_B_W'(r_item.sk);
            end
            B_Q1: begin
                mul_a = MUL_A_W'(i_cfg.cq);
                mul_b = MUL_B_W'(r_item.w);
            end
            B_Q2: begin
                mul_a = r_t >> 16;
                mul_b = MUL_B_W'(r_item.sk);
            end
            B_G1: begin
                mul_a = r_t;
                mul_b = MUL_B_W'(S_W'(r_item.nut) + S_W'(r_item.nu));
            end
            B_G2: begin
                mul_a = r_t;
                mul_b = MUL_B_W'(r_item.grad);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = !r_wait && (r_state == B_D || r_state == B_N1 || r_state == B_N2
                     || r_state == B_N3 || r_state == B_Q1 || r_state == B_Q2
                     || r_state == B_G1 || r_state == B_G2);
    assign div_start = !r_wait && (r_state == B_DIV1 || r_state == B_DIV2);
    assign div_num   = (r_state == B_DIV2) ? r_n2 : r_n;

    rwe_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    rwe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_d),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // cell sums: dissipation low, production high
    assign idx       = IDX_W'(r_item.cell_idx);
    assign out_free  = !r_ovalid || i_ready;
    assign dis_sum   = {1'b0, ram_rdata[SUM_W-1:0]} + {1'b0, r_eps};
    assign prod_sum  = {1'b0, ram_rdata[RAM_W-1:SUM_W]} + {1'b0, r_gen};
    assign n_dis     = dis_sum[SUM_W] ? SUM_MAX : dis_sum[SUM_W-1:0];
    assign n_prod    = prod_sum[SUM_W] ? SUM_MAX : prod_sum[SUM_W-1:0];
    assign ram_we    = (r_state == B_CLEAR) || (r_state == B_ACC && out_free);
    assign ram_waddr = (r_state == B_CLEAR) ? r_clr : idx;
    assign ram_wdata = (r_state == B_CLEAR) ? '0 : {n_prod, n_dis};

    rwe_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (idx),
        .o_rdata (ram_rdata)
    );

    assign o_clearing = (r_state == B_CLEAR);
    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign o_valid    = r_ovalid;
    assign o_data     = r_odata;
    assign o_user     = r_ouser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLEAR;
            r_clr    <= '0;
            r_wait   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == B_ACC && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (mul_start || div_start) begin
                r_wait <= 1'b1;
            end
            unique case (r_state)
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_W'(CELL_COUNT - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_empty) begin
                        r_item  <= i_head;
                        r_state <= B_D;
                    end
                end
                B_D: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_d     <= r_item.lowre ? mul_p : mul_p << 16;
                        r_state <= B_N1;
                    end
                end
                B_N1: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= mul_p;
                        r_state <= B_N2;
                    end
                end
                B_N2: begin
                    if (mul_done) begin
                        r_wait <= 1'b0;
                        if (r_item.lowre) begin
                            r_n     <= mul_p << 1;
                            r_state <= B_DIV1;
                        end else begin
                            r_t     <= mul_p;
                            r_state <= B_N3;
                        end
                    end
                end
                B_N3: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_n     <= mul_p;
                        r_state <= B_Q1;
                    end
                end
                B_Q1: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= mul_p;
                        r_state <= B_Q2;
                    end
                end
                B_Q2: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= mul_p;
                        r_state <= B_G1;
                    end
                end
                B_G1: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_t     <= mul_p;
                        r_state <= B_G2;
                    end
                end
                B_G2: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_n2    <= mul_p;
                        r_state <= B_DIV1;
                    end
                end
                B_DIV1: begin
                    if (div_done) begin
                        r_wait <= 1'b0;
                        r_eps  <= div_quo;
                        if (r_item.lowre) begin
                            r_gen   <= '0;
                            r_state <= B_RD;
                        end else begin
                            r_state <= B_DIV2;
                        end
                    end
                end
                B_DIV2: begin
                    if (div_done) begin
                        r_wait  <= 1'b0;
                        r_gen   <= div_quo;
                        r_state <= B_RD;
                    end
                end
                B_RD: r_state <= B_ACC;
                B_ACC: begin
                    if (out_free) begin
                        r_odata  <= {{PAD_W{1'b0}}, n_prod, n_dis, r_item.cell_idx};
                        r_ouser  <= r_item.lowre;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

/* hdl/rough_wall_epsilon_accumulate_top.sv */
// Top level of the rough-wall epsilon accumulator: configuration registers,
// front, queue and back. Depends on rwe_pkg, rwe_front, rwe_queue, rwe_back.
//
//  channel   direction  accept when                 payload
//  s_*       in         i_s_tvalid & o_s_tready     i_s_tdata: one wall face
//  m_*       out        o_m_tvalid & i_m_tready     o_m_tdata + o_m_tuser: cell sums
//  cfg_*     in         i_cfg_we                    i_cfg_addr, i_cfg_wdata
//
// Front: per face, 24 square-root steps and three multiplies.
// Back: per face, products on the shared 8-bit-digit multiplier and quotients on
// the bit-serial divider, more of both for a high-Re face than for a low-Re face.
// The back sets the sustained rate. After reset the back zeroes the sum memory
// with o_s_tready low. A stalled result holds the back; the queue then fills and
// the front waits to push.
module rough_wall_epsilon_accumulate_top #(
    parameter int CELL_COUNT = rwe_pkg::CELL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request in
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // cell_index[9:0], wall_distance[41:10], kinetic_energy[73:42],
    // laminar_viscosity[105:74], turbulent_viscosity[137:106],
    // velocity_gradient[169:138], roughness_length[201:170],
    // corner_weight[218:202], zero fill
    input  logic [rwe_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // request out
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // out_cell[9:0], dissipation_total[49:10], production_total[89:50], zero fill
    output logic [rwe_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // low_re_applied[0]
    output logic                            o_m_tuser,
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [rwe_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [rwe_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import rwe_pkg::*;

    t_cfg  r_cfg;
    t_item front_item, head_item;
    logic  push, pop, q_full, q_empty, clearing;

    // registers are only to be written by the user while the block is idle; the block does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cq    <= RST_CMU_QUARTER;
            r_cfg.c75   <= RST_CMU_THREE_QUARTER;
            r_cfg.kappa <= RST_VON_KARMAN;
            r_cfg.yl    <= RST_YPLUS_LAMINAR;
            r_cfg.en    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CMU_QUARTER:       r_cfg.cq    <= i_cfg_wdata;
                CFG_CMU_THREE_QUARTER: r_cfg.c75   <= i_cfg_wdata;
                CFG_VON_KARMAN:        r_cfg.kappa <= i_cfg_wdata;
                CFG_YPLUS_LAMINAR:     r_cfg.yl    <= i_cfg_wdata;
                CFG_LOW_RE_ENABLE:     r_cfg.en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    rwe_front #(
        .CELL_COUNT (CELL_COUNT)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_hold  (clearing),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_data  (i_s_tdata),
        .o_push  (push),
        .o_item  (front_item),
        .i_full  (q_full)
    );

    rwe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_head  (head_item),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rwe_back #(
        .CELL_COUNT (CELL_COUNT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .o_clearing (clearing),
        .i_head     (head_item),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_data     (o_m_tdata),
        .o_user     (o_m_tuser)
    );
endmodule

/* hdl/rwe_checker.sv */
// Port-level checks of the accumulator top level, bound to it.
// Depends on rwe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rwe_port_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [rwe_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                            o_m_tuser
);
    `RWE_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid,
        "result dropped while stalled")
    `RWE_ASSERT(a_out_stable, i_clk, i_rst_n,
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tuser),
        "result changed while stalled")
    `RWE_ASSERT_RST(a_rst_out, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid right after reset")
    `RWE_ASSERT_RST(a_rst_clear, i_clk, !i_rst_n |=> !o_s_tready, "input taken during memory clear")
endmodule

bind rough_wall_epsilon_accumulate_top rwe_port_checker u_rwe_checker (.*);
